FILE: sv/dwsmc_pkg.sv
package dwsmc_pkg;

	// Item opcodes
	typedef enum logic {
		OP_START = 1'b0,
		OP_TICK  = 1'b1
	} op_t;

	// One motor's two pin levels: pin1 level and pin2 PWM duty
	typedef struct packed {
		logic       pin1;
		logic [7:0] duty;
	} motor_pins_t;

	localparam motor_pins_t MOTOR_OFF = '{pin1: 1'b0, duty: 8'd0};

	// Map a wheel drive request to pin levels.
	// Positive power: pin1 low, duty on pin2. Negative: pin1 high, duty 0.
	// Zero power (not driven or speed 0): both low.
	// flip inverts the power sign (left wheel is mounted mirrored).
	function automatic motor_pins_t drive_pins(input logic drive, input logic reverse,
			input logic flip, input logic [7:0] spd);
		motor_pins_t p;
		p = MOTOR_OFF;
		if (drive && (spd != 8'd0)) begin
			if (reverse ^ flip) begin
				p.pin1 = 1'b1;
			end else begin
				p.duty = spd;
			end
		end
		return p;
	endfunction

endpackage

FILE: sv/dwsmc_in_if.sv
interface dwsmc_in_if #(
	parameter int STEP_WIDTH = 16
);
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic signed [STEP_WIDTH-1:0] steps_left;
	logic signed [STEP_WIDTH-1:0] steps_right;
	logic [7:0]                   speed;
	logic [14:0]                  sync_limit;
	logic                         enc_left;
	logic                         enc_right;

	modport source (output valid, op, steps_left, steps_right, speed, sync_limit,
		enc_left, enc_right, input ready);
	modport sink (input valid, op, steps_left, steps_right, speed, sync_limit,
		enc_left, enc_right, output ready);
endinterface

FILE: sv/dwsmc_out_if.sv
interface dwsmc_out_if #(
	parameter int STEP_WIDTH = 16
);
	logic                       valid;
	logic                       ready;
	logic                       busy_res;
	logic                       a_pin1;
	logic [7:0]                 a_pin2_duty;
	logic                       b_pin1;
	logic [7:0]                 b_pin2_duty;
	logic signed [STEP_WIDTH:0] left_left_to_go;
	logic signed [STEP_WIDTH:0] right_left_to_go;

	modport source (output valid, busy_res, a_pin1, a_pin2_duty, b_pin1, b_pin2_duty,
		left_left_to_go, right_left_to_go, input ready);
	modport sink (input valid, busy_res, a_pin1, a_pin2_duty, b_pin1, b_pin2_duty,
		left_left_to_go, right_left_to_go, output ready);
endinterface

FILE: sv/dual_wheel_step_move_controller.sv
// Path: a result passes through the input register, then the move state / result
// register.
// Throughput: one item per cycle while results are taken; the input register lets one item enter while a
// result waits to be taken.
// Reset: arst_n clears the move, counts, encoder history and all motor pins (off).
module dual_wheel_step_move_controller
	import dwsmc_pkg::*;
#(
	parameter int STEP_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	dwsmc_in_if.sink     cmd,
	dwsmc_out_if.source  res
);

	localparam int CW = STEP_WIDTH + 1;
	localparam int DW = (STEP_WIDTH + 2 > 16) ? STEP_WIDTH + 2 : 16;
	localparam logic signed [CW-1:0] CNT_MIN = {2'b11, {(STEP_WIDTH-1){1'b0}}};

	// Input register
	logic                         valid_s1;
	op_t                          op_s1;
	logic signed [STEP_WIDTH-1:0] steps_left_s1;
	logic signed [STEP_WIDTH-1:0] steps_right_s1;
	logic [7:0]                   speed_s1;
	logic [14:0]                  sync_limit_s1;
	logic                         enc_left_s1;
	logic                         enc_right_s1;

	// Move state; also serves as the result register
	logic                 res_valid_q;
	logic                 in_progress_q;
	logic signed [CW-1:0] left_count_q;
	logic signed [CW-1:0] right_count_q;
	logic                 left_rev_q;
	logic                 right_rev_q;
	logic                 prev_enc_left_q;
	logic                 prev_enc_right_q;
	logic [7:0]           speed_q;
	logic [14:0]          sync_limit_q;
	motor_pins_t          a_pins_q;
	motor_pins_t          b_pins_q;

	logic                 in_progress_d;
	logic signed [CW-1:0] left_count_d;
	logic signed [CW-1:0] right_count_d;
	logic                 left_rev_d;
	logic                 right_rev_d;
	logic [7:0]           speed_d;
	logic [14:0]          sync_limit_d;
	motor_pins_t          a_pins_d;
	motor_pins_t          b_pins_d;

	logic                 advance;
	logic                 update;
	logic signed [CW-1:0] sl_ext;
	logic signed [CW-1:0] sr_ext;
	logic signed [CW-1:0] lc_dec;
	logic signed [CW-1:0] rc_dec;
	logic signed [DW-1:0] diff_rl;
	logic signed [DW-1:0] diff_lr;
	logic signed [DW-1:0] lim_ext;
	logic                 drive_l;
	logic                 drive_r;

	// Handshake
	assign advance   = !res_valid_q || res.ready;
	assign cmd.ready = !valid_s1 || advance;
	assign update    = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1          <= op_t'(cmd.op);
			steps_left_s1  <= cmd.steps_left;
			steps_right_s1 <= cmd.steps_right;
			speed_s1       <= cmd.speed;
			sync_limit_s1  <= cmd.sync_limit;
			enc_left_s1    <= cmd.enc_left;
			enc_right_s1   <= cmd.enc_right;
		end
	end

	// Count decrement on encoder toggle, saturating at -2^(STEP_WIDTH-1)
	assign sl_ext = CW'(steps_left_s1);
	assign sr_ext = CW'(steps_right_s1);
	assign lc_dec = ((enc_left_s1 != prev_enc_left_q) && (left_count_q != CNT_MIN)) ?
		left_count_q - CW'(1) : left_count_q;
	assign rc_dec = ((enc_right_s1 != prev_enc_right_q) && (right_count_q != CNT_MIN)) ?
		right_count_q - CW'(1) : right_count_q;

	// Sync check on the decremented counts
	assign diff_rl = DW'(rc_dec) - DW'(lc_dec);
	assign diff_lr = DW'(lc_dec) - DW'(rc_dec);
	assign lim_ext = $signed({{(DW-15){1'b0}}, sync_limit_q});
	assign drive_l = (lc_dec > 0) && ((sync_limit_q == 15'd0) || (diff_rl < lim_ext));
	assign drive_r = (rc_dec > 0) && ((sync_limit_q == 15'd0) || (diff_lr < lim_ext));

	// Next move state
	always_comb begin
		in_progress_d = in_progress_q;
		left_count_d  = left_count_q;
		right_count_d = right_count_q;
		left_rev_d    = left_rev_q;
		right_rev_d   = right_rev_q;
		speed_d       = speed_q;
		sync_limit_d  = sync_limit_q;
		a_pins_d      = a_pins_q;
		b_pins_d      = b_pins_q;
		case (op_s1)
			OP_START: begin
				in_progress_d = 1'b1;
				left_count_d  = (sl_ext < 0) ? -sl_ext : sl_ext;
				right_count_d = (sr_ext < 0) ? -sr_ext : sr_ext;
				left_rev_d    = !(sl_ext > 0);
				right_rev_d   = !(sr_ext > 0);
				speed_d       = speed_s1;
				sync_limit_d  = sync_limit_s1;
			end
			OP_TICK: begin
				if (in_progress_q) begin
					left_count_d  = lc_dec;
					right_count_d = rc_dec;
					if ((lc_dec <= 0) && (rc_dec <= 0)) begin
						in_progress_d = 1'b0;
						a_pins_d      = MOTOR_OFF;
						b_pins_d      = MOTOR_OFF;
					end else begin
						a_pins_d = drive_pins(drive_r, right_rev_q, 1'b0, speed_q);
						b_pins_d = drive_pins(drive_l, left_rev_q, 1'b1, speed_q);
					end
				end
			end
			default: begin
			end
		endcase
	end

	// State / result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q      <= 1'b0;
			in_progress_q    <= 1'b0;
			left_count_q     <= '0;
			right_count_q    <= '0;
			left_rev_q       <= 1'b0;
			right_rev_q      <= 1'b0;
			prev_enc_left_q  <= 1'b0;
			prev_enc_right_q <= 1'b0;
			speed_q          <= '0;
			sync_limit_q     <= '0;
			a_pins_q         <= MOTOR_OFF;
			b_pins_q         <= MOTOR_OFF;
		end else begin
			if (advance) begin
				res_valid_q <= valid_s1;
			end
			if (update) begin
				in_progress_q <= in_progress_d;
				left_count_q  <= left_count_d;
				right_count_q <= right_count_d;
				left_rev_q    <= left_rev_d;
				right_rev_q   <= right_rev_d;
				speed_q       <= speed_d;
				sync_limit_q  <= sync_limit_d;
				a_pins_q      <= a_pins_d;
				b_pins_q      <= b_pins_d;
				// encoders are sampled by starts and by ticks of a running move
				if ((op_s1 == OP_START) || in_progress_q) begin
					prev_enc_left_q  <= enc_left_s1;
					prev_enc_right_q <= enc_right_s1;
				end
			end
		end
	end

	// Result fields
	assign res.valid            = res_valid_q;
	assign res.busy_res         = in_progress_q;
	assign res.a_pin1           = a_pins_q.pin1;
	assign res.a_pin2_duty      = a_pins_q.duty;
	assign res.b_pin1           = b_pins_q.pin1;
	assign res.b_pin2_duty      = b_pins_q.duty;
	assign res.left_left_to_go  = left_count_q;
	assign res.right_left_to_go = right_count_q;

endmodule

FILE: sv/dwsmc_checker.sv
module dwsmc_checker #(
	parameter int STEP_WIDTH = 16
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic                       busy_res,
	input logic                       a_pin1,
	input logic [7:0]                 a_pin2_duty,
	input logic                       b_pin1,
	input logic [7:0]                 b_pin2_duty,
	input logic signed [STEP_WIDTH:0] left_left_to_go,
	input logic signed [STEP_WIDTH:0] right_left_to_go
);

	// A stalled result keeps its busy flag and its remaining counts
	ap_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(busy_res) &&
		$stable(left_left_to_go) && $stable(right_left_to_go))
		else $error("result changed while stalled");

	// A reversing motor never carries duty at the same time
	ap_pin_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (!a_pin1 || (a_pin2_duty == 8'd0)) &&
		(!b_pin1 || (b_pin2_duty == 8'd0)))
		else $error("pin1 high with nonzero duty");

	// With no move running, both motors are off
	ap_idle_off: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> !a_pin1 && !b_pin1 &&
		(a_pin2_duty == 8'd0) && (b_pin2_duty == 8'd0))
		else $error("motor driven while idle");

	// A finished move has no steps left on either wheel
	ap_idle_done: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !busy_res |-> (left_left_to_go <= 0) && (right_left_to_go <= 0))
		else $error("idle with steps remaining");

endmodule

bind dual_wheel_step_move_controller dwsmc_checker #(
	.STEP_WIDTH(STEP_WIDTH)
) u_dwsmc_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.busy_res         (res.busy_res),
	.a_pin1           (res.a_pin1),
	.a_pin2_duty      (res.a_pin2_duty),
	.b_pin1           (res.b_pin1),
	.b_pin2_duty      (res.b_pin2_duty),
	.left_left_to_go  (res.left_left_to_go),
	.right_left_to_go (res.right_left_to_go)
);

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import dwsmc_pkg::*;

	localparam int STEP_WIDTH   = 16;
	localparam int CNT_FLOOR    = -(1 << (STEP_WIDTH - 1));
	localparam int RANDOM_ITEMS = 1550;
	localparam int STALL_PCT    = 19;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int MAX_PRINTS   = 40;

	// One command item as driven on the cmd channel
	typedef struct {
		op_t                          op;
		logic signed [STEP_WIDTH-1:0] steps_l;
		logic signed [STEP_WIDTH-1:0] steps_r;
		logic [7:0]                   speed;
		logic [14:0]                  lead;
		logic                         enc_l;
		logic                         enc_r;
	} cmd_item_t;

	// One status item as seen on the res channel
	typedef struct {
		logic                       busy;
		logic                       a_pin1;
		logic [7:0]                 a_duty;
		logic                       b_pin1;
		logic [7:0]                 b_duty;
		logic signed [STEP_WIDTH:0] left_go;
		logic signed [STEP_WIDTH:0] right_go;
	} move_result_t;

	// Tracks the move state and holds the status items still owed by the block
	class move_scoreboard;
		bit           moving;
		int           left_go;
		int           right_go;
		bit           left_rev;
		bit           right_rev;
		bit           last_enc_l;
		bit           last_enc_r;
		bit [7:0]     duty_cmd;
		int           lead_limit;
		bit           a_pin1;
		bit [7:0]     a_duty;
		bit           b_pin1;
		bit [7:0]     b_duty;
		move_result_t status_q[$];
		int           errors;

		// Remaining count drops by one, sticking at the floor
		function int count_down(int c);
			return (c > CNT_FLOOR) ? c - 1 : c;
		endfunction

		// Called on every cmd transfer
		function void note_item(cmd_item_t it);
			move_result_t r;
			bit drive_l;
			bit drive_r;
			int sl;
			int sr;
			if (it.op == OP_START) begin
				// new move replaces whatever runs; pins keep their levels
				sl = int'(it.steps_l);
				sr = int'(it.steps_r);
				moving = 1'b1;
				left_go = (sl < 0) ? -sl : sl;
				right_go = (sr < 0) ? -sr : sr;
				left_rev = !(sl > 0);
				right_rev = !(sr > 0);
				last_enc_l = it.enc_l;
				last_enc_r = it.enc_r;
				duty_cmd = it.speed;
				lead_limit = int'(it.lead);
			end else if (moving) begin
				if (it.enc_l != last_enc_l) left_go = count_down(left_go);
				if (it.enc_r != last_enc_r) right_go = count_down(right_go);
				last_enc_l = it.enc_l;
				last_enc_r = it.enc_r;
				if (left_go <= 0 && right_go <= 0) begin
					moving = 1'b0;
					a_pin1 = 1'b0;
					a_duty = '0;
					b_pin1 = 1'b0;
					b_duty = '0;
				end else begin
					drive_l = left_go > 0 &&
						(lead_limit == 0 || right_go - left_go < lead_limit);
					drive_r = right_go > 0 &&
						(lead_limit == 0 || left_go - right_go < lead_limit);
					// right wheel on motor A, same sense
					a_pin1 = drive_r && duty_cmd != 0 && right_rev;
					a_duty = (drive_r && !right_rev) ? duty_cmd : 8'd0;
					// left wheel on motor B, mounted mirrored
					b_pin1 = drive_l && duty_cmd != 0 && !left_rev;
					b_duty = (drive_l && left_rev) ? duty_cmd : 8'd0;
				end
			end
			r.busy = moving;
			r.a_pin1 = a_pin1;
			r.a_duty = a_duty;
			r.b_pin1 = b_pin1;
			r.b_duty = b_duty;
			r.left_go = left_go[STEP_WIDTH:0];
			r.right_go = right_go[STEP_WIDTH:0];
			status_q.push_back(r);
		endfunction

		task report_mismatch(string msg);
			errors++;
			if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
		endtask

		task check_field(string name, logic signed [31:0] got, logic signed [31:0] want);
			if (got !== want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
		endtask

		// Called on every res transfer
		task check_result(move_result_t got);
			move_result_t want;
			if (status_q.size() == 0) begin
				report_mismatch("status transfer with nothing outstanding");
				return;
			end
			want = status_q.pop_front();
			check_field("busy_res", 32'(got.busy), 32'(want.busy));
			check_field("a_pin1", 32'(got.a_pin1), 32'(want.a_pin1));
			check_field("a_pin2_duty", 32'(got.a_duty), 32'(want.a_duty));
			check_field("b_pin1", 32'(got.b_pin1), 32'(want.b_pin1));
			check_field("b_pin2_duty", 32'(got.b_duty), 32'(want.b_duty));
			check_field("left_left_to_go", 32'(got.left_go), 32'(want.left_go));
			check_field("right_left_to_go", 32'(got.right_go), 32'(want.right_go));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	bit   enc_l = 1'b0;
	bit   enc_r = 1'b0;

	move_scoreboard tracker;

	dwsmc_in_if  #(.STEP_WIDTH(STEP_WIDTH)) cmd_if ();
	dwsmc_out_if #(.STEP_WIDTH(STEP_WIDTH)) res_if ();

	dual_wheel_step_move_controller #(.STEP_WIDTH(STEP_WIDTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if),
		.res    (res_if)
	);

	always #2 clk = ~clk;

	// Random gap unless steady, then hold the item until its transfer
	task automatic send_item(cmd_item_t it);
		if (!steady) begin
			while ($urandom_range(99) < STALL_PCT) begin
				cmd_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_if.valid <= 1'b1;
		cmd_if.op <= it.op;
		cmd_if.steps_left <= it.steps_l;
		cmd_if.steps_right <= it.steps_r;
		cmd_if.speed <= it.speed;
		cmd_if.sync_limit <= it.lead;
		cmd_if.enc_left <= it.enc_l;
		cmd_if.enc_right <= it.enc_r;
		do @(posedge clk); while (!cmd_if.ready);
		tracker.note_item(it);
	endtask

	// Encoder sample; tl/tr flip the encoder levels, move fields are junk
	task automatic tick(bit tl, bit tr);
		cmd_item_t it;
		enc_l ^= tl;
		enc_r ^= tr;
		it.op = OP_TICK;
		it.steps_l = STEP_WIDTH'($urandom);
		it.steps_r = STEP_WIDTH'($urandom);
		it.speed = 8'($urandom);
		it.lead = 15'($urandom);
		it.enc_l = enc_l;
		it.enc_r = enc_r;
		send_item(it);
	endtask

	task automatic start_move(int sl, int sr, int spd, int lead);
		cmd_item_t it;
		it.op = OP_START;
		it.steps_l = STEP_WIDTH'(sl);
		it.steps_r = STEP_WIDTH'(sr);
		it.speed = 8'(spd);
		it.lead = 15'(lead);
		it.enc_l = enc_l;
		it.enc_r = enc_r;
		send_item(it);
	endtask

	// Mostly short moves, some long ones, a few anywhere in range
	function automatic int pick_target();
		int r;
		int mag;
		logic signed [STEP_WIDTH-1:0] any;
		r = $urandom_range(99);
		if (r < 5) begin
			any = STEP_WIDTH'($urandom);
			return int'(any);
		end
		mag = (r < 85) ? $urandom_range(12) : $urandom_range(300);
		return $urandom_range(1) ? mag : -mag;
	endfunction

	// Status sink: check on transfer, stall at random
	initial begin : status_sink
		move_result_t seen;
		res_if.ready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (res_if.valid && res_if.ready) begin
				seen.busy = res_if.busy_res;
				seen.a_pin1 = res_if.a_pin1;
				seen.a_duty = res_if.a_pin2_duty;
				seen.b_pin1 = res_if.b_pin1;
				seen.b_duty = res_if.b_pin2_duty;
				seen.left_go = res_if.left_left_to_go;
				seen.right_go = res_if.right_left_to_go;
				tracker.check_result(seen);
			end
			res_if.ready <= steady || ($urandom_range(99) >= STALL_PCT);
		end
	end

	// Watchdog: too long without any transfer ends the run
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin : stimulus
		int sent;
		int ticks;
		int cap;
		int r;
		int spd;
		int lead;
		tracker = new();
		cmd_if.valid <= 1'b0;
		cmd_if.op <= OP_START;
		cmd_if.steps_left <= '0;
		cmd_if.steps_right <= '0;
		cmd_if.speed <= '0;
		cmd_if.sync_limit <= '0;
		cmd_if.enc_left <= 1'b0;
		cmd_if.enc_right <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: idle tick, full speed move to its end, restarts, extremes
		tick(1, 1);
		start_move(3, -2, 255, 0);
		tick(1, 1);
		tick(1, 0);
		tick(0, 0);
		tick(1, 1);
		tick(0, 1);
		// zero targets end on the first tick
		start_move(0, 0, 0, 0);
		tick(0, 0);
		// largest targets, speed zero keeps both motors off
		start_move(32767, CNT_FLOOR, 0, 32767);
		tick(1, 0);
		tick(0, 1);
		// restart mid-move; tight sync limit holds the left wheel back
		start_move(2, 6, 255, 1);
		tick(0, 0);
		tick(0, 1);
		tick(1, 1);
		start_move(-1, 1, 1, 2);
		tick(0, 0);
		tick(1, 1);

		// Hold off until the directed status items are all back
		cmd_if.valid <= 1'b0;
		while (tracker.status_q.size() != 0) @(posedge clk);

		// Random moves with random encoder activity, plus noise items
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			steady = (sent >= 700 && sent < 950);
			if ($urandom_range(99) < 12) begin
				enc_l = 1'($urandom);
				enc_r = 1'($urandom);
				if ($urandom_range(1)) begin
					start_move($urandom, $urandom, $urandom, $urandom);
					sent++;
				end else begin
					if (tracker.moving) sent++;
					tick(0, 0);
				end
			end else begin
				r = $urandom_range(99);
				spd = (r < 10) ? 0 : (r < 20) ? 255 : $urandom_range(255);
				r = $urandom_range(99);
				lead = (r < 40) ? 0 : (r < 80) ? $urandom_range(1, 4) : $urandom_range(32767);
				enc_l ^= 1'($urandom_range(1));
				enc_r ^= 1'($urandom_range(1));
				start_move(pick_target(), pick_target(), spd, lead);
				sent++;
				// a short cap leaves the move running so the next start replaces it
				cap = ($urandom_range(99) < 10) ? $urandom_range(1, 6) : 120;
				ticks = 0;
				while (tracker.moving && ticks < cap) begin
					tick($urandom_range(99) < 55, $urandom_range(99) < 55);
					sent++;
					ticks++;
				end
				if (!tracker.moving) begin
					repeat ($urandom_range(2)) tick(1'($urandom_range(1)), 1'($urandom_range(1)));
				end
			end
		end

		// Drain
		cmd_if.valid <= 1'b0;
		while (tracker.status_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
